// ===== src/vector3_length_normalize_top_defines.svh =====
// Assertion macros for the vector length and normalize block.
// Used by the checker file only; needs i_clk and i_rst_n in scope.
`ifndef VECTOR3_LENGTH_NORMALIZE_TOP_DEFINES_SVH
`define VECTOR3_LENGTH_NORMALIZE_TOP_DEFINES_SVH

// Implication checked on every edge outside reset.
`define VLN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked during reset too.
`define VLN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/vln_pkg.sv =====
// Shared types and constants for the vector length and normalize block.
// No dependencies.
`default_nettype none
package vln_pkg;
    localparam int DATA_W      = 32;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 31;
    localparam int QUEUE_DEPTH = 2;

    // Word passed from the front end through the queue to the back end.
    typedef struct packed {
        logic [63:0] sum;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] mag_z;
        logic [2:0]  neg;
        logic        zero;
    } t_item;

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] mag_z;
        logic [2:0]  neg;
        logic        zero;
    } t_sq;

    typedef struct packed {
        logic [31:0] len;
        logic [31:0] rem_x;
        logic [31:0] rem_y;
        logic [31:0] rem_z;
        logic [30:0] q_x;
        logic [30:0] q_y;
        logic [30:0] q_z;
        logic [2:0]  neg;
        logic        zero;
    } t_dv;
endpackage
`default_nettype wire

// ===== src/vector3_length_normalize_top.sv =====
// Top level: 3D vector length and unit vector, Q16.16 in, Q16.16 / Q2.30 out.
// Depends on vln_pkg, vln_front, vln_queue, vln_back.
//
//   channel   handshake            payload
//   input     start / busy         i_comp_x, i_comp_y, i_comp_z
//   result    o_valid (strobe)     o_length, o_unit_x/y/z, o_zero_vector
//
// One vector per cycle while busy is low; each result passes through
// 3 front stages, the queue, 32 root stages, 31 divide stages and output.
// The root and divide pipelines retire one bit per stage.
// Synchronous active-low reset clears only valid bits and queue counters.
// busy rises only if the queue fills; the back end never stalls.
`default_nettype none
module vector3_length_normalize_top #(
    parameter int QUEUE_DEPTH = vln_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_comp_x,
    input  wire logic signed [31:0] i_comp_y,
    input  wire logic signed [31:0] i_comp_z,
    output logic                    o_valid,
    output logic [31:0]             o_length,
    output logic signed [31:0]      o_unit_x,
    output logic signed [31:0]      o_unit_y,
    output logic signed [31:0]      o_unit_z,
    output logic                    o_zero_vector
);
    logic           full, empty, push;
    vln_pkg::t_item f_item, q_item;
    logic [31:0]    ux, uy, uz;

    assign busy = full;

    vln_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (start && !busy),
        .i_full   (full),
        .i_comp_x (i_comp_x),
        .i_comp_y (i_comp_y),
        .i_comp_z (i_comp_z),
        .o_push   (push),
        .o_item   (f_item)
    );

    vln_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (!empty),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (q_item)
    );

    vln_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!empty),
        .i_item        (q_item),
        .o_valid       (o_valid),
        .o_length      (o_length),
        .o_unit_x      (ux),
        .o_unit_y      (uy),
        .o_unit_z      (uz),
        .o_zero_vector (o_zero_vector)
    );

    assign o_unit_x = $signed(ux);
    assign o_unit_y = $signed(uy);
    assign o_unit_z = $signed(uz);
endmodule
`default_nettype wire

// ===== src/vln_front.sv =====
// Front end: take a vector, form magnitudes, squares and their sum.
// Depends on vln_pkg.
`default_nettype none
module vln_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_full,
    input  wire logic [31:0]        i_comp_x,
    input  wire logic [31:0]        i_comp_y,
    input  wire logic [31:0]        i_comp_z,
    output logic                    o_push,
    output vln_pkg::t_item          o_item
);
    logic        r_v1, r_v2, r_v3;
    logic [31:0] r_mx, r_my, r_mz;
    logic [2:0]  r_neg1, r_neg2;
    logic [63:0] r_sx, r_sy, r_sz;
    logic [31:0] r_mx2, r_my2, r_mz2;
    logic        r_zero2;
    vln_pkg::t_item r_item;
    logic        advance;

    assign advance = !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (advance) begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            // two's complement magnitude; -2^31 maps to 2^31
            r_mx   <= i_comp_x[31] ? (~i_comp_x + 32'd1) : i_comp_x;
            r_my   <= i_comp_y[31] ? (~i_comp_y + 32'd1) : i_comp_y;
            r_mz   <= i_comp_z[31] ? (~i_comp_z + 32'd1) : i_comp_z;
            r_neg1 <= {i_comp_z[31], i_comp_y[31], i_comp_x[31]};
            r_sx    <= r_mx * r_mx;
            r_sy    <= r_my * r_my;
            r_sz    <= r_mz * r_mz;
            r_mx2   <= r_mx;
            r_my2   <= r_my;
            r_mz2   <= r_mz;
            r_neg2  <= r_neg1;
            r_zero2 <= (r_mx == 32'd0) && (r_my == 32'd0) && (r_mz == 32'd0);
            r_item.sum   <= r_sx + r_sy + r_sz;
            r_item.mag_x <= r_mx2;
            r_item.mag_y <= r_my2;
            r_item.mag_z <= r_mz2;
            r_item.zero  <= r_zero2;
            r_item.neg   <= r_neg2;
        end
    end

    assign o_item = r_item;
    assign o_push = r_v3 && advance;
endmodule
`default_nettype wire

// ===== src/vln_queue.sv =====
// Short queue between front and back ends.
// Depends on vln_pkg.
`default_nettype none
module vln_queue #(
    parameter int DEPTH = vln_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  vln_pkg::t_item          i_item,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output vln_pkg::t_item          o_item
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    vln_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end
endmodule
`default_nettype wire

// ===== src/vln_back.sv =====
// Back end: pipelined square root, then three pipelined dividers.
// Depends on vln_pkg. One root bit and one quotient bit per stage.
`default_nettype none
module vln_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  vln_pkg::t_item          i_item,
    output logic                    o_valid,
    output logic [31:0]             o_length,
    output logic [31:0]             o_unit_x,
    output logic [31:0]             o_unit_y,
    output logic [31:0]             o_unit_z,
    output logic                    o_zero_vector
);
    localparam int NS = vln_pkg::SQRT_STEPS;
    localparam int ND = vln_pkg::DIV_STEPS;

    vln_pkg::t_sq r_sq [NS];
    logic         r_sq_v [NS];
    vln_pkg::t_sq c_sq_src [NS];
    vln_pkg::t_dv r_dv [ND];
    logic         r_dv_v [ND];
    vln_pkg::t_dv c_dv_src [ND];
    logic [2:0]   c_bit [ND];
    logic         r_out_v;

    function automatic logic [32:0] div_step(input logic [31:0] rem, input logic b,
                                             input logic [31:0] len);
        logic [32:0] r2;
        logic [32:0] d;
        r2 = {rem, b};
        d  = {1'b0, len};
        if (r2 >= d) begin
            div_step = {r2[31:0] - len, 1'b1};
        end else begin
            div_step = {r2[31:0], 1'b0};
        end
    endfunction

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_sqrt
            logic [35:0] rem_sh;
            logic [35:0] trial;
            vln_pkg::t_sq n_sq;
            if (gi == 0) begin : g_src0
                always_comb begin
                    c_sq_src[gi].rad   = i_item.sum;
                    c_sq_src[gi].rem   = '0;
                    c_sq_src[gi].root  = '0;
                    c_sq_src[gi].mag_x = i_item.mag_x;
                    c_sq_src[gi].mag_y = i_item.mag_y;
                    c_sq_src[gi].mag_z = i_item.mag_z;
                    c_sq_src[gi].neg   = i_item.neg;
                    c_sq_src[gi].zero  = i_item.zero;
                end
            end else begin : g_srcn
                assign c_sq_src[gi] = r_sq[gi-1];
            end
            assign rem_sh = {c_sq_src[gi].rem, c_sq_src[gi].rad[63:62]};
            assign trial  = {2'b00, c_sq_src[gi].root, 2'b01};
            always_comb begin
                n_sq     = c_sq_src[gi];
                n_sq.rad = {c_sq_src[gi].rad[61:0], 2'b00};
                if (rem_sh >= trial) begin
                    n_sq.rem  = 34'(rem_sh - trial);
                    n_sq.root = {c_sq_src[gi].root[30:0], 1'b1};
                end else begin
                    n_sq.rem  = rem_sh[33:0];
                    n_sq.root = {c_sq_src[gi].root[30:0], 1'b0};
                end
            end
            always_ff @(posedge i_clk) begin
                r_sq[gi] <= n_sq;
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_v[gi] <= 1'b0;
                end else begin
                    r_sq_v[gi] <= (gi == 0) ? i_valid : r_sq_v[(gi == 0) ? 0 : gi-1];
                end
            end
        end

        for (gi = 0; gi < ND; gi++) begin : g_div
            logic [32:0] sx, sy, sz;
            vln_pkg::t_dv n_dv;
            if (gi == 0) begin : g_src0
                // start with mag/2 so the remainder stays below the length
                always_comb begin
                    c_dv_src[gi].len   = r_sq[NS-1].root;
                    c_dv_src[gi].rem_x = {1'b0, r_sq[NS-1].mag_x[31:1]};
                    c_dv_src[gi].rem_y = {1'b0, r_sq[NS-1].mag_y[31:1]};
                    c_dv_src[gi].rem_z = {1'b0, r_sq[NS-1].mag_z[31:1]};
                    c_dv_src[gi].q_x   = '0;
                    c_dv_src[gi].q_y   = '0;
                    c_dv_src[gi].q_z   = '0;
                    c_dv_src[gi].neg   = r_sq[NS-1].neg;
                    c_dv_src[gi].zero  = r_sq[NS-1].zero;
                    c_bit[gi] = {r_sq[NS-1].mag_z[0], r_sq[NS-1].mag_y[0],
                                 r_sq[NS-1].mag_x[0]};
                end
            end else begin : g_srcn
                assign c_dv_src[gi] = r_dv[gi-1];
                assign c_bit[gi]    = 3'b000;
            end
            assign sx = div_step(c_dv_src[gi].rem_x, c_bit[gi][0], c_dv_src[gi].len);
            assign sy = div_step(c_dv_src[gi].rem_y, c_bit[gi][1], c_dv_src[gi].len);
            assign sz = div_step(c_dv_src[gi].rem_z, c_bit[gi][2], c_dv_src[gi].len);
            always_comb begin
                n_dv       = c_dv_src[gi];
                n_dv.rem_x = sx[32:1];
                n_dv.rem_y = sy[32:1];
                n_dv.rem_z = sz[32:1];
                n_dv.q_x   = {c_dv_src[gi].q_x[29:0], sx[0]};
                n_dv.q_y   = {c_dv_src[gi].q_y[29:0], sy[0]};
                n_dv.q_z   = {c_dv_src[gi].q_z[29:0], sz[0]};
            end
            always_ff @(posedge i_clk) begin
                r_dv[gi] <= n_dv;
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_v[gi] <= 1'b0;
                end else begin
                    r_dv_v[gi] <= (gi == 0) ? r_sq_v[NS-1] : r_dv_v[(gi == 0) ? 0 : gi-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_dv_v[ND-1];
        end
    end

    // apply sign; force zero units on a zero vector
    always_ff @(posedge i_clk) begin
        o_length      <= r_dv[ND-1].len;
        o_zero_vector <= r_dv[ND-1].zero;
        if (r_dv[ND-1].zero) begin
            o_unit_x <= '0;
            o_unit_y <= '0;
            o_unit_z <= '0;
        end else begin
            o_unit_x <= r_dv[ND-1].neg[0] ? (32'd0 - {1'b0, r_dv[ND-1].q_x})
                                          : {1'b0, r_dv[ND-1].q_x};
            o_unit_y <= r_dv[ND-1].neg[1] ? (32'd0 - {1'b0, r_dv[ND-1].q_y})
                                          : {1'b0, r_dv[ND-1].q_y};
            o_unit_z <= r_dv[ND-1].neg[2] ? (32'd0 - {1'b0, r_dv[ND-1].q_z})
                                          : {1'b0, r_dv[ND-1].q_z};
        end
    end

    assign o_valid = r_out_v;
endmodule
`default_nettype wire

// ===== src/vln_checker.sv =====
// Port-level checks for the vector length and normalize block, bound to the top.
// Depends on vector3_length_normalize_top_defines.svh.
`default_nettype none
`include "vector3_length_normalize_top_defines.svh"
module vln_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               busy,
    input wire logic               o_valid,
    input wire logic [31:0]        o_length,
    input wire logic signed [31:0] o_unit_x,
    input wire logic signed [31:0] o_unit_y,
    input wire logic signed [31:0] o_unit_z,
    input wire logic               o_zero_vector
);
    localparam logic signed [31:0] UNIT_MAX = 32'sd1073741824;

    logic units_zero;
    logic units_in_range;

    assign units_zero = (o_unit_x == 32'sd0) && (o_unit_y == 32'sd0) &&
                        (o_unit_z == 32'sd0);
    assign units_in_range = (o_unit_x <= UNIT_MAX) && (o_unit_x >= -UNIT_MAX) &&
                            (o_unit_y <= UNIT_MAX) && (o_unit_y >= -UNIT_MAX) &&
                            (o_unit_z <= UNIT_MAX) && (o_unit_z >= -UNIT_MAX);

    `VLN_ASSERT_IMP(a_zero_out, o_valid && o_zero_vector, (o_length == 32'd0) && units_zero, "zero vector with nonzero fields")
    `VLN_ASSERT_IMP(a_len_nz, o_valid && !o_zero_vector, o_length != 32'd0, "nonzero vector with zero length")
    `VLN_ASSERT_IMP(a_unit_rng, o_valid, units_in_range, "unit component out of range")
    `VLN_ASSERT_NEXT(a_rst_quiet, !i_rst_n, !o_valid && !busy, "activity right after reset")
endmodule

bind vector3_length_normalize_top vln_checker u_vln_checker (.*);
`default_nettype wire

// ===== bench/vector3_length_normalize_top_tb.sv =====
// Testbench for vector3_length_normalize_top: length and unit vector of Q16.16 vectors.
// Depends on vln_pkg and the block's RTL; predicts each result and checks it as it comes.
`timescale 1ns / 100ps
`default_nettype none
module vector3_length_normalize_top_tb;
    localparam int LATENCY  = 67;
    localparam int WDOG_MAX = 4000;

    typedef struct {
        logic [31:0] length;
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] uz;
        logic        zv;
    } t_norm;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_comp_x = '0;
    logic signed [31:0] i_comp_y = '0;
    logic signed [31:0] i_comp_z = '0;
    logic               o_valid;
    logic [31:0]        o_length;
    logic signed [31:0] o_unit_x;
    logic signed [31:0] o_unit_y;
    logic signed [31:0] o_unit_z;
    logic               o_zero_vector;

    t_norm expected_norms[$];
    int    n_mismatch = 0;
    int    n_sent = 0;
    int    n_checked = 0;
    int    n_zero = 0;
    int    idle_pct = 0;
    int    wdog = 0;

    vector3_length_normalize_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_comp_x(i_comp_x), .i_comp_y(i_comp_y), .i_comp_z(i_comp_z),
        .o_valid(o_valid), .o_length(o_length), .o_unit_x(o_unit_x),
        .o_unit_y(o_unit_y), .o_unit_z(o_unit_z), .o_zero_vector(o_zero_vector)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'h1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] unit_comp(input logic [31:0] c, input logic [31:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        mag = c[31] ? {32'h0, -c} : {32'h0, c};
        if (c == 32'h8000_0000) mag = 64'h8000_0000;
        q = (mag << 30) / {32'h0, len};
        if (c[31]) q = -q;
        return q[31:0];
    endfunction

    function automatic t_norm normalize(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z);
        t_norm r;
        logic [63:0] mx, my, mz;
        logic [63:0] root64;
        mx = x[31] ? {32'h0, -x} : {32'h0, x};
        my = y[31] ? {32'h0, -y} : {32'h0, y};
        mz = z[31] ? {32'h0, -z} : {32'h0, z};
        root64 = floor_root(mx * mx + my * my + mz * mz);
        r.length = root64[31:0];
        r.zv = (r.length == 0);
        if (r.zv) begin
            r.ux = 0; r.uy = 0; r.uz = 0;
        end else begin
            r.ux = unit_comp(x, r.length);
            r.uy = unit_comp(y, r.length);
            r.uz = unit_comp(z, r.length);
        end
        return r;
    endfunction

    task automatic send_vector(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_comp_x <= x;
        i_comp_y <= y;
        i_comp_z <= z;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_norms.push_back(normalize(x, y, z));
        n_sent++;
        if (x == 0 && y == 0 && z == 0) n_zero++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_norms.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5, 0))
            0: return $urandom_range(65535, 0);
            1: return -$urandom_range(65535, 0);
            2: return $urandom_range(3, 0) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_vector(0, 0, 0);
        send_vector(32'h0001_0000, 0, 0);
        send_vector(0, 32'hffff_0000, 0);
        send_vector(0, 0, 32'h0000_0001);
        send_vector(32'h8000_0000, 0, 0);
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vector(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_vector(32'h0003_0000, 32'h0004_0000, 0);
        send_vector(32'h0001_0000, 32'h0002_0000, 32'h0002_0000);
        send_vector(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff);
        send_vector(0, 0, 0);
        // hold off until everything sent so far has come back
        drain_results();
        send_vector(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    endtask

    task automatic test_random(input int count, input int pct);
        idle_pct = pct;
        repeat (count) send_vector(rand_comp(), rand_comp(), rand_comp());
        idle_pct = 0;
    endtask

    always @(posedge i_clk) begin
        t_norm e;
        if (i_rst_n && o_valid) begin
            if (expected_norms.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result word, length %h", o_length);
            end else begin
                e = expected_norms.pop_front();
                n_checked++;
                if (o_length !== e.length || o_unit_x !== e.ux || o_unit_y !== e.uy ||
                    o_unit_z !== e.uz || o_zero_vector !== e.zv) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
                            e.length, e.ux, e.uy, e.uz, e.zv, o_length, o_unit_x,
                            o_unit_y, o_unit_z, o_zero_vector);
                end
            end
        end
    end

    // count cycles with no word moving in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("timeout with %0d results outstanding", expected_norms.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400, 0);
        test_random(400, 64);
        test_random(350, 22);
        test_random(350, 0);
        drain_results();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (expected_norms.size() != 0) n_mismatch++;
        $display("sent %0d vectors (%0d zero), checked %0d results, %0d mismatches",
            n_sent, n_zero, n_checked, n_mismatch);
        if (n_mismatch == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
